@@ rtl/core/spq_pkg.sv @@
package spq_pkg;

  localparam int DataW = 32;
  localparam int PrioW = 32;
  localparam int FillOutW = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // what a cell shows its neighbors; keep = holds an entry that stays ahead of the new one
  typedef struct packed {
    logic                    valid;
    logic                    keep;
    logic signed [PrioW-1:0] prio;
    logic signed [DataW-1:0] data;
  } link_t;

  // broadcast to every cell for one request
  typedef struct packed {
    logic                    ins;
    logic                    rem;
    logic signed [PrioW-1:0] prio;
    logic signed [DataW-1:0] data;
  } cmd_t;

endpackage

@@ rtl/core/spq_cell.sv @@
module spq_cell import spq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cmd_t  cmd,
  input  link_t left,   // toward the head
  input  link_t right,  // toward the tail
  output link_t self
);

  logic                    valid;
  logic signed [PrioW-1:0] prio;
  logic signed [DataW-1:0] data;
  logic                    keep;

  // equal priority stays ahead: FIFO among equals
  assign keep = valid && (prio >= cmd.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins) begin
      if (!keep) begin
        valid <= valid | left.valid;
      end
    end else if (cmd.rem) begin
      valid <= right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (!keep) begin
        if (left.keep) begin
          prio <= cmd.prio;
          data <= cmd.data;
        end else begin
          prio <= left.prio;
          data <= left.data;
        end
      end
    end else if (cmd.rem) begin
      prio <= right.prio;
      data <= right.data;
    end
  end

  assign self = '{valid: valid, keep: keep, prio: prio, data: data};

endmodule

@@ rtl/core/sorted_priority_queue_top.sv @@
// Channel  Dir  Signals                      Content
// s_*      in   s_tvalid s_tready s_tdata    request: op, data, priority
//                s_tuser
// m_*      out  m_tvalid m_tready m_tdata    result: status, data, priority, fill
//                m_tuser
//
// One request per cycle: every cell compares against the new priority and
// shifts in parallel, and the result lands in the output register next cycle.
// s_tready drops only while a result sits unaccepted in the output register.
// Reset clears the cell valid bits and the fill counter; no clearing pass.
module sorted_priority_queue_top import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] item_data, [63:32] item_prio
  input  logic        s_tuser,   // [0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] out_data, [63:32] out_prio,
                                 // [68:64] fill_count, [71:69] zero
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int FillW = $clog2(DEPTH + 1);
  localparam int ExtW  = (FillW > FillOutW) ? FillW : FillOutW;

  logic accept;
  op_t  op;
  logic full;
  logic empty;
  cmd_t cmd;

  link_t links [DEPTH];
  link_t head_edge;
  link_t tail_edge;
  logic [DEPTH-1:0] valid_vec;

  logic [FillW-1:0] fill;
  logic [FillW-1:0] fill_next;
  logic [ExtW-1:0]  fill_ext;

  status_t                 status;
  status_t                 status_next;
  logic signed [DataW-1:0] out_data;
  logic signed [PrioW-1:0] out_prio;
  logic [FillOutW-1:0]     out_fill;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign full     = links[DEPTH-1].valid;
  assign empty    = !links[0].valid;

  assign cmd.ins  = accept && (op == OP_INSERT) && !full;
  assign cmd.rem  = accept && (op == OP_REMOVE) && !empty;
  assign cmd.data = s_tdata[31:0];
  assign cmd.prio = s_tdata[63:32];

  // the head sees a kept, valid entry in front; the tail sees nothing behind
  assign head_edge = '{valid: 1'b1, keep: 1'b1, prio: '0, data: '0};
  assign tail_edge = '{valid: 1'b0, keep: 1'b0, prio: '0, data: '0};

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  ((i == 0) ? head_edge : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? tail_edge : links[(i == DEPTH - 1) ? 0 : i + 1]),
      .self  (links[i])
    );
    assign valid_vec[i] = links[i].valid;
  end

  always_comb begin
    fill_next   = fill;
    status_next = STATUS_OK;
    if (op == OP_INSERT) begin
      if (full) begin
        status_next = STATUS_FULL;
      end else begin
        fill_next = fill + FillW'(1);
      end
    end else begin
      if (empty) begin
        status_next = STATUS_EMPTY;
      end else begin
        fill_next = fill - FillW'(1);
      end
    end
  end

  assign fill_ext = ExtW'(fill_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        fill     <= fill_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      out_fill <= fill_ext[FillOutW-1:0];
      if (cmd.rem) begin
        out_data <= links[0].data;
        out_prio <= links[0].prio;
      end else begin
        out_data <= '0;
        out_prio <= '0;
      end
    end
  end

  assign m_tdata = {3'b000, out_fill, out_prio, out_data};
  assign m_tuser = status;

  a_fill_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(fill))
    else $error("fill counter disagrees with cell valid bits");

  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("valid cells do not form a prefix");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    links[1].valid |-> (links[0].prio >= links[1].prio))
    else $error("head entry out of priority order");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_INSERT && full) |=> ($stable(fill) && m_tuser == STATUS_FULL))
    else $error("insert into full queue changed state");

  a_empty_reported: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_REMOVE && empty) |=> (m_tuser == STATUS_EMPTY && fill == '0))
    else $error("remove from empty queue not reported");

endmodule

@@ verif/spq_checker.sv @@
module spq_checker import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] item_data, [63:32] item_prio
  input  logic        s_tuser,   // [0] op
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,   // [31:0] out_data, [63:32] out_prio,
                                 // [68:64] fill_count, [71:69] zero
  input  logic [1:0]  m_tuser,   // [1:0] status
  output int          mismatches,
  output int          results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t                 status;
    logic [2:0]              pad;
    logic [FillOutW-1:0]     fill;
    logic signed [PrioW-1:0] prio;
    logic signed [DataW-1:0] data;
  } pq_result_t;

  // shadow copy of the sorted array, head at index 0
  logic signed [DataW-1:0] held_data [DEPTH];
  logic signed [PrioW-1:0] held_prio [DEPTH];
  int                      held_count = 0;
  pq_result_t              pq_results_due[$];
  int                      fail_total = 0;

  function automatic pq_result_t pq_apply(op_t op, logic signed [DataW-1:0] data,
                                          logic signed [PrioW-1:0] prio);
    pq_result_t r;
    int         pos;
    r.status = STATUS_OK;
    r.pad    = '0;
    r.data   = '0;
    r.prio   = '0;
    if (op == OP_INSERT) begin
      if (held_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        // new entry goes behind every entry of greater or equal priority
        pos = held_count;
        while (pos > 0 && held_prio[pos-1] < prio) begin
          held_data[pos] = held_data[pos-1];
          held_prio[pos] = held_prio[pos-1];
          pos--;
        end
        held_data[pos] = data;
        held_prio[pos] = prio;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.data = held_data[0];
      r.prio = held_prio[0];
      for (int i = 1; i < held_count; i++) begin
        held_data[i-1] = held_data[i];
        held_prio[i-1] = held_prio[i];
      end
      held_count--;
    end
    r.fill = FillOutW'(held_count);
    return r;
  endfunction

  always @(posedge clk) begin
    pq_result_t want;
    pq_result_t got;
    if (rst) begin
      held_count = 0;
      pq_results_due.delete();
    end else begin
      // result side first: a result always belongs to an earlier request
      if (m_tvalid && m_tready) begin
        got.status = status_t'(m_tuser);
        got.pad    = m_tdata[71:69];
        got.fill   = m_tdata[68:64];
        got.prio   = m_tdata[63:32];
        got.data   = m_tdata[31:0];
        if (pq_results_due.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: result with no request pending: status %0d data %h prio %h fill %0d",
                     $realtime, got.status, got.data, got.prio, got.fill);
        end else begin
          want = pq_results_due.pop_front();
          if (got.status != want.status || got.pad != want.pad || got.fill != want.fill ||
              got.prio != want.prio || got.data != want.data) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: mismatch: expected status %0d data %h prio %h fill %0d pad %0d,",
                       $realtime, want.status, want.data, want.prio, want.fill, want.pad,
                       " got status %0d data %h prio %h fill %0d pad %0d",
                       got.status, got.data, got.prio, got.fill, got.pad);
          end
        end
      end
      if (s_tvalid && s_tready)
        pq_results_due.push_back(pq_apply(op_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]));
    end
    mismatches  <= fail_total;
    results_due <= pq_results_due.size();
  end

endmodule

@@ verif/sorted_priority_queue_top_test.sv @@
module sorted_priority_queue_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int Depth      = 16;
  localparam int RandItems  = 2000;
  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 2000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata  = '0;
  logic        s_tuser  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [1:0]  m_tuser;
  int          mismatches;
  int          results_due;
  int          idle_cycles = 0;
  bit          hold_off_req = 1'b0;

  always #6 clk = ~clk;

  sorted_priority_queue_top #(.DEPTH(Depth)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  spq_checker #(.DEPTH(Depth)) checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // holds valid high on return; caller lowers it when a gap follows
  task automatic offer_request(input op_t op, input logic [31:0] data,
                               input logic [31:0] prio);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {prio, data};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int          sent;
    int          burst;
    int          gap;
    int          ins_pct;
    op_t         op;
    logic [31:0] data;
    logic [31:0] prio;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer_request(OP_REMOVE, 32'h0, 32'h0);
    offer_request(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    offer_request(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    offer_request(OP_INSERT, 32'h8000_0000, 32'h8000_0000);
    offer_request(OP_INSERT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    // ties must leave in arrival order; this also fills the queue
    for (int i = 0; i < Depth - 4; i++)
      offer_request(OP_INSERT, 32'(i + 1), (i % 3 == 0) ? 32'h7FFF_FFFF : 32'd5);
    offer_request(OP_INSERT, 32'h1234_5678, 32'h7FFF_FFFF);
    offer_request(OP_REMOVE, 32'h0, 32'h0);
    offer_request(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_request(OP_INSERT, 32'hA5A5_5A5A, 32'h8000_0000);
    offer_request(OP_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    s_tvalid <= 1'b0;
    @(posedge clk);

    sent = 0;
    while (sent < RandItems) begin
      burst = $urandom_range(1, 40);
      // the insert bias swings the fill level between empty and full
      case ($urandom_range(0, 2))
        0:       ins_pct = 20;
        1:       ins_pct = 50;
        default: ins_pct = 85;
      endcase
      for (int k = 0; k < burst && sent < RandItems; k++) begin
        if (sent == 600) hold_off_req = 1'b1;
        op   = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
        data = $urandom;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: prio = $urandom_range(0, 6) - 3;
          6, 7, 8:          prio = $urandom;
          default: begin
            case ($urandom_range(0, 3))
              0:       prio = 32'h7FFF_FFFF;
              1:       prio = 32'h8000_0000;
              2:       prio = 32'h0;
              default: prio = 32'hFFFF_FFFF;
            endcase
          end
        endcase
        offer_request(op, data, prio);
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;

    // the pending count is registered, so it lags behind the last request
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("sorted_priority_queue_top_test OK");
    else
      $display("sorted_priority_queue_top_test NOT OK");
    $finish;
  end

  initial begin : sink
    int mode;
    int span;
    int hold;
    int phase;
    mode  = 0;
    span  = 0;
    hold  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold = HoldCycles;
      end
      if (hold > 0) begin
        // long stall so the block backs up into the request side
        hold--;
        m_tready <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(20, 200);
        end
        span--;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= $urandom_range(0, 1);
          2:       m_tready <= (phase % 5) < 3;
          default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("sorted_priority_queue_top_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ files.f @@
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_top.sv
verif/spq_checker.sv
verif/sorted_priority_queue_top_test.sv
